// ===== sv/ckrot_pkg.sv =====
// Package for the Cayley-Klein rotation block: datapath commands, controller states,
// fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package ckrot_pkg;

  // Width of the controller step counter; it covers up to 32 steps.
  localparam int CNT_W = 5;

  // Fixed-point constants, angles in Q.30.
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q30_TWO_PI  = 35'sd6746518852;
  localparam logic signed [33:0] Q30_GAIN    = 34'sd652032875;
  localparam logic signed [17:0] ONE_Q16     = 18'sd65536;

  // Configuration register indexes.
  localparam logic [1:0] REG_POSITION  = 2'd0;
  localparam logic [1:0] REG_PHASE_COS = 2'd1;
  localparam logic [1:0] REG_PHASE_SIN = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PROD,
    OP_SQR,
    OP_SQRT,
    OP_SQRT_FIN,
    OP_DIV_INIT,
    OP_DIV,
    OP_CORDIC,
    OP_CS_RND,
    OP_SCALE,
    OP_MAC,
    OP_COMMIT
  } dp_op_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROD,
    ST_SQR,
    ST_SQRT,
    ST_SQRT_FIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_CORDIC,
    ST_CS_RND,
    ST_SCALE,
    ST_MAC,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // Arctangent of 2^-i in Q.30; past the table it is 2^(30-i).
  function automatic logic signed [34:0] atan_q30(input logic [CNT_W-1:0] i);
    logic signed [34:0] v;
    case (i)
      5'd0: v = 35'sd843314857;
      5'd1: v = 35'sd497837829;
      5'd2: v = 35'sd263043837;
      5'd3: v = 35'sd133525159;
      5'd4: v = 35'sd67021687;
      5'd5: v = 35'sd33543516;
      5'd6: v = 35'sd16775851;
      5'd7: v = 35'sd8388437;
      5'd8: v = 35'sd4194283;
      5'd9: v = 35'sd2097149;
      default: v = 35'sd1 <<< (6'd30 - {1'b0, i});
    endcase
    return v;
  endfunction

endpackage

// ===== sv/ckrot_ctrl.sv =====
// Controller for the Cayley-Klein rotation block: sequences the datapath phases.
// Depends on ckrot_pkg.
module ckrot_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ckrot_pkg::dp_stat_t stat,
  output ckrot_pkg::dp_cmd_t  cmd
);
  import ckrot_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // State and step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = OP_NONE;
    cmd.cnt   = cnt_r;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_PROD;
          cnt_nxt   = '0;
        end
      end
      ST_PROD: begin
        cmd.op = OP_PROD;
        if (cnt_r == CNT_W'(2)) begin
          state_nxt = ST_SQR;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQR: begin
        cmd.op = OP_SQR;
        if (cnt_r == CNT_W'(2)) begin
          state_nxt = ST_SQRT;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == CNT_W'(15)) begin
          state_nxt = ST_SQRT_FIN;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SQRT_FIN: begin
        cmd.op    = OP_SQRT_FIN;
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        state_nxt = ST_DIV;
        cnt_nxt   = '0;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(17)) begin
          state_nxt = ST_CORDIC;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_CS_RND;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CS_RND: begin
        cmd.op    = OP_CS_RND;
        state_nxt = ST_SCALE;
        cnt_nxt   = '0;
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        if (cnt_r == CNT_W'(2)) begin
          state_nxt = ST_MAC;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MAC: begin
        cmd.op = OP_MAC;
        if (cnt_r == CNT_W'(15)) begin
          state_nxt = ST_DONE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_COMMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ckrot_dp.sv =====
// Datapath for the Cayley-Klein rotation block: shared multiplier, square root,
// three-lane divider, CORDIC, spinor state and output register. Depends on ckrot_pkg.
module ckrot_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ckrot_pkg::dp_cmd_t  cmd,
  output ckrot_pkg::dp_stat_t stat,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic signed [15:0]  in_rf_sample,
  input  logic signed [15:0]  in_gradient_sample,
  input  logic                in_first,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [17:0]  out_alpha_re,
  output logic signed [17:0]  out_alpha_im,
  output logic signed [17:0]  out_beta_re,
  output logic signed [17:0]  out_beta_im,
  output logic                out_final_res
);
  import ckrot_pkg::*;

  // Configuration and input registers.
  logic signed [15:0] pos_r, pcos_r, psin_r;
  logic signed [15:0] rf_r, gr_r;
  logic               last_r;
  // Angle components: cg, cpr, cpi.
  logic signed [15:0] comp_r [3];
  // Square root.
  logic [31:0]        sum_r, sv_r, sr_r;
  logic [30:0]        sbit_r;
  logic [16:0]        phi_r;
  // Division lanes.
  logic [17:0]        drem_r [3];
  logic [17:0]        dnum_r [3];
  logic [17:0]        dq_r   [3];
  // CORDIC.
  logic signed [34:0] z_r;
  logic signed [33:0] x_r, y_r;
  logic               flip_r;
  logic signed [17:0] c_r, s_r;
  // al1, be0, be1.
  logic signed [17:0] k_r [3];
  // Spinor state a0, a1, b0, b1 and its next value.
  logic signed [17:0] st_r  [4];
  logic signed [17:0] nst_r [4];
  logic signed [37:0] acc_r;
  logic               out_valid_r;
  logic signed [17:0] o_r [4];
  logic               ofin_r;

  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod;
  logic               mac_neg;

  assign stat.out_busy = out_valid_r && out_stall;

  // Signed axis component of one lane; (0,0,1) when the angle is zero.
  function automatic logic signed [17:0] axis(input int j);
    logic signed [17:0] q;
    q = $signed(dq_r[j]);
    if (phi_r == '0) begin
      return (j == 0) ? ONE_Q16 : 18'sd0;
    end
    return comp_r[j][15] ? -q : q;
  endfunction

  // Shared multiplier operand selection.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mac_neg = 1'b0;
    case (cmd.op)
      OP_PROD: begin
        case (cmd.cnt[1:0])
          2'd0: begin
            mul_a = 18'(pos_r);
            mul_b = 18'(gr_r);
          end
          2'd1: begin
            mul_a = 18'(rf_r);
            mul_b = 18'(pcos_r);
          end
          default: begin
            mul_a = 18'(rf_r);
            mul_b = 18'(psin_r);
          end
        endcase
      end
      OP_SQR: begin
        mul_a = 18'(comp_r[cmd.cnt[1:0]]);
        mul_b = 18'(comp_r[cmd.cnt[1:0]]);
      end
      OP_SCALE: begin
        mul_b = s_r;
        case (cmd.cnt[1:0])
          2'd0:    mul_a = axis(0);
          2'd1:    mul_a = axis(2);
          default: mul_a = axis(1);
        endcase
      end
      OP_MAC: begin
        // Terms of a' = al*a - be*conj(b) and b' = al*b + be*conj(a).
        case (cmd.cnt[3:0])
          4'd0:  begin mul_a = c_r;    mul_b = st_r[0]; end
          4'd1:  begin mul_a = k_r[0]; mul_b = st_r[1]; mac_neg = 1'b1; end
          4'd2:  begin mul_a = k_r[1]; mul_b = st_r[2]; mac_neg = 1'b1; end
          4'd3:  begin mul_a = k_r[2]; mul_b = st_r[3]; mac_neg = 1'b1; end
          4'd4:  begin mul_a = c_r;    mul_b = st_r[1]; end
          4'd5:  begin mul_a = k_r[0]; mul_b = st_r[0]; end
          4'd6:  begin mul_a = k_r[2]; mul_b = st_r[2]; mac_neg = 1'b1; end
          4'd7:  begin mul_a = k_r[1]; mul_b = st_r[3]; end
          4'd8:  begin mul_a = c_r;    mul_b = st_r[2]; end
          4'd9:  begin mul_a = k_r[0]; mul_b = st_r[3]; mac_neg = 1'b1; end
          4'd10: begin mul_a = k_r[1]; mul_b = st_r[0]; end
          4'd11: begin mul_a = k_r[2]; mul_b = st_r[1]; end
          4'd12: begin mul_a = c_r;    mul_b = st_r[3]; end
          4'd13: begin mul_a = k_r[0]; mul_b = st_r[2]; end
          4'd14: begin mul_a = k_r[2]; mul_b = st_r[0]; end
          default: begin mul_a = k_r[1]; mul_b = st_r[1]; mac_neg = 1'b1; end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // Rounded and saturated angle product.
  logic signed [35:0] prod_rnd;
  logic signed [15:0] prod_sat;
  always_comb begin
    if (cmd.cnt[1:0] == 2'd0) begin
      prod_rnd = (prod + 36'sd2048) >>> 12;
    end else begin
      prod_rnd = (prod + 36'sd8192) >>> 14;
    end
    if (prod_rnd > 36'sd32767) begin
      prod_sat = 16'sh7fff;
    end else if (prod_rnd < -36'sd32768) begin
      prod_sat = 16'sh8000;
    end else begin
      prod_sat = prod_rnd[15:0];
    end
  end

  // Square root step.
  logic [31:0] sq_trial;
  assign sq_trial = sr_r + {1'b0, sbit_r};

  // Division numerators and steps.
  logic [32:0] dnum_init [3];
  logic [18:0] dtrial    [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dnum_init[j] = {1'b0, (comp_r[j][15] ? 16'(-comp_r[j]) : 16'(comp_r[j])), 16'b0}
                     + {17'b0, phi_r[16:1]};
      dtrial[j]    = {drem_r[j], dnum_r[j][17]};
    end
  end

  // Half angle taken to Q.30 and folded into [-pi/2, pi/2].
  logic signed [34:0] z_wrap, z_fold;
  logic               fold;
  always_comb begin
    z_wrap = $signed({1'b0, phi_r, 17'b0});
    if (z_wrap > Q30_PI) begin
      z_wrap = z_wrap - Q30_TWO_PI;
    end
    z_fold = z_wrap;
    fold   = 1'b0;
    if (z_wrap > Q30_HALF_PI) begin
      z_fold = Q30_PI - z_wrap;
      fold   = 1'b1;
    end else if (z_wrap < -Q30_HALF_PI) begin
      z_fold = -Q30_PI - z_wrap;
      fold   = 1'b1;
    end
  end

  // Rounded cosine and sine.
  logic signed [33:0] x_rnd, y_rnd;
  assign x_rnd = (x_r + 34'sd8192) >>> 14;
  assign y_rnd = (y_r + 34'sd8192) >>> 14;

  // Multiply-accumulate and final rounding of one spinor part.
  logic signed [37:0] acc_sum, acc_rnd;
  logic signed [17:0] acc_sat;
  always_comb begin
    acc_sum = (cmd.cnt[1:0] == 2'd0) ? 38'sd0 : acc_r;
    acc_sum = mac_neg ? acc_sum - 38'(prod) : acc_sum + 38'(prod);
    acc_rnd = (acc_sum + 38'sd32768) >>> 16;
    if (acc_rnd > 38'sd131071) begin
      acc_sat = 18'sh1ffff;
    end else if (acc_rnd < -38'sd131072) begin
      acc_sat = 18'sh20000;
    end else begin
      acc_sat = acc_rnd[17:0];
    end
  end

  logic signed [35:0] scale_rnd;
  assign scale_rnd = (prod + 36'sd32768) >>> 16;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      pcos_r <= 16'sd16384;
      psin_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_POSITION:  pos_r  <= cfg_data;
        REG_PHASE_COS: pcos_r <= cfg_data;
        REG_PHASE_SIN: psin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Spinor state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r[0] <= ONE_Q16;
      st_r[1] <= '0;
      st_r[2] <= '0;
      st_r[3] <= '0;
    end else if (cmd.op == OP_LOAD && in_first) begin
      st_r[0] <= ONE_Q16;
      st_r[1] <= '0;
      st_r[2] <= '0;
      st_r[3] <= '0;
    end else if (cmd.op == OP_COMMIT) begin
      for (int j = 0; j < 4; j++) begin
        st_r[j] <= nst_r[j];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_COMMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      for (int j = 0; j < 4; j++) begin
        o_r[j] <= nst_r[j];
      end
      ofin_r <= last_r;
    end
  end

  // Working registers of one item.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        rf_r   <= in_rf_sample;
        gr_r   <= in_gradient_sample;
        last_r <= in_last;
        sum_r  <= '0;
      end
      OP_PROD: begin
        comp_r[cmd.cnt[1:0]] <= prod_sat;
      end
      OP_SQR: begin
        sum_r <= sum_r + prod[31:0];
        sv_r  <= sum_r + prod[31:0];
        sr_r  <= '0;
        sbit_r <= 31'h40000000;
      end
      OP_SQRT: begin
        if (sv_r >= sq_trial) begin
          sv_r <= sv_r - sq_trial;
          sr_r <= (sr_r >> 1) + {1'b0, sbit_r};
        end else begin
          sr_r <= sr_r >> 1;
        end
        sbit_r <= sbit_r >> 2;
      end
      OP_SQRT_FIN: begin
        phi_r <= sr_r[16:0] + {16'b0, (sv_r > sr_r)};
      end
      OP_DIV_INIT: begin
        for (int j = 0; j < 3; j++) begin
          drem_r[j] <= {3'b0, dnum_init[j][32:18]};
          dnum_r[j] <= dnum_init[j][17:0];
          dq_r[j]   <= '0;
        end
        z_r    <= z_fold;
        flip_r <= fold;
        x_r    <= Q30_GAIN;
        y_r    <= '0;
      end
      OP_DIV: begin
        for (int j = 0; j < 3; j++) begin
          if (dtrial[j] >= {2'b0, phi_r}) begin
            drem_r[j] <= 18'(dtrial[j] - {2'b0, phi_r});
            dq_r[j]   <= {dq_r[j][16:0], 1'b1};
          end else begin
            drem_r[j] <= dtrial[j][17:0];
            dq_r[j]   <= {dq_r[j][16:0], 1'b0};
          end
          dnum_r[j] <= {dnum_r[j][16:0], 1'b0};
        end
      end
      OP_CORDIC: begin
        if (z_r >= 0) begin
          x_r <= x_r - (y_r >>> cmd.cnt);
          y_r <= y_r + (x_r >>> cmd.cnt);
          z_r <= z_r - atan_q30(cmd.cnt);
        end else begin
          x_r <= x_r + (y_r >>> cmd.cnt);
          y_r <= y_r - (x_r >>> cmd.cnt);
          z_r <= z_r + atan_q30(cmd.cnt);
        end
      end
      OP_CS_RND: begin
        c_r <= flip_r ? -x_rnd[17:0] : x_rnd[17:0];
        s_r <= y_rnd[17:0];
      end
      OP_SCALE: begin
        k_r[cmd.cnt[1:0]] <= scale_rnd[17:0];
      end
      OP_MAC: begin
        acc_r <= acc_sum;
        if (cmd.cnt[1:0] == 2'd3) begin
          nst_r[cmd.cnt[3:2]] <= acc_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_alpha_re  = o_r[0];
  assign out_alpha_im  = o_r[1];
  assign out_beta_re   = o_r[2];
  assign out_beta_im   = o_r[3];
  assign out_final_res = ofin_r;

endmodule

// ===== sv/cayley_klein_rf_rotation.sv =====
// Top level of the Cayley-Klein rotation block: controller and datapath.
// Depends on ckrot_pkg, ckrot_ctrl and ckrot_dp.
//
//   Port group  Direction  Handshake            Carries
//   in_         input      in_valid / in_stall  rf_sample, gradient_sample, first, last
//   out_        output     out_valid/out_stall  alpha_re/im, beta_re/im, final_res
//   cfg_        input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// From acceptance to its result an item passes through the shared multiplier, the
// 16-step square root, the 18-step divider lanes and the CORDIC loop. Items are
// taken one at a time.
// Reset is synchronous; after it alpha is one and beta zero.
// A stalled result holds only the final commit of the following item; a new item
// can be taken in the cycle after each commit.
module cayley_klein_rf_rotation #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_rf_sample,
  input  logic signed [15:0]  in_gradient_sample,
  input  logic                in_first,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [17:0]  out_alpha_re,
  output logic signed [17:0]  out_alpha_im,
  output logic signed [17:0]  out_beta_re,
  output logic signed [17:0]  out_beta_im,
  output logic                out_final_res,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import ckrot_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Registers are always writable.
  assign cfg_ready = 1'b1;

  ckrot_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ckrot_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_rf_sample       (in_rf_sample),
    .in_gradient_sample (in_gradient_sample),
    .in_first           (in_first),
    .in_last            (in_last),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_alpha_re       (out_alpha_re),
    .out_alpha_im       (out_alpha_im),
    .out_beta_re        (out_beta_re),
    .out_beta_im        (out_beta_im),
    .out_final_res      (out_final_res)
  );

endmodule

// ===== sv/ckrot_chk.sv =====
// Port checker for the Cayley-Klein rotation block, bound to its top level.
// Depends on cayley_klein_rf_rotation.
module ckrot_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_alpha_re,
  input logic        cfg_ready
);

  // A held result stays valid and its alpha_re part unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_alpha_re))
    else $error("held result changed");

  // After an item is taken the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while busy");

  // No result right after reset.
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Register writes are never refused.
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind cayley_klein_rf_rotation ckrot_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_alpha_re (out_alpha_re),
  .cfg_ready    (cfg_ready)
);

// ===== tb/cayley_klein_rf_rotation_tb.sv =====
// Testbench for the Cayley-Klein rotation block: random and directed RF/gradient items,
// checked against a bit-exact fixed-point predictor held in a small scoreboard class.
// Depends on ckrot_pkg and cayley_klein_rf_rotation.
`timescale 1ns / 1ps

module cayley_klein_rf_rotation_tb;
  import ckrot_pkg::*;

  localparam int STEPS = 16;
  localparam longint LIMIT_CYCLES = 2000000;

  typedef struct {
    logic signed [17:0] are;
    logic signed [17:0] aim;
    logic signed [17:0] bre;
    logic signed [17:0] bim;
    logic fin;
  } spinor_t;

  // Scoreboard: keeps the rotation state and registers, queues predicted spinors.
  class spinor_board;
    longint pos, pcos, psin;
    longint ar, ai, br, bi;
    spinor_t pending[$];
    int errors;

    function new();
      pos = 0; pcos = 16384; psin = 0;
      ar = 65536; ai = 0; br = 0; bi = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_POSITION: pos = longint'($signed(val));
        REG_PHASE_COS: pcos = longint'($signed(val));
        REG_PHASE_SIN: psin = longint'($signed(val));
        default: ;
      endcase
    endfunction

    // Arithmetic shift with round half up.
    function longint rshift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint root_round(longint v);
      longint r, b;
      r = 0;
      b = longint'(1) << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      if (v > r) r++;
      return r;
    endfunction

    function longint unit_part(longint comp, longint phi);
      longint m, q;
      m = (comp < 0 ? -comp : comp) << 16;
      q = (m + phi / 2) / phi;
      return comp < 0 ? -q : q;
    endfunction

    function longint rf_ext(logic signed [15:0] v);
      return longint'(v);
    endfunction

    // Notes an accepted item and predicts its spinor.
    function void note_item(logic signed [15:0] rf, logic signed [15:0] gr, logic f, logic l);
      longint cg, cpr, cpi, phi, nx, ny, nz, z, x, y, t, at, c, s, al1, be0, be1;
      longint na0, na1, nb0, nb1;
      bit flip;
      spinor_t e;
      if (f) begin
        ar = 65536; ai = 0; br = 0; bi = 0;
      end
      cg = clip(rshift(pos * rf_ext(gr), 12), -32768, 32767);
      cpr = clip(rshift(rf_ext(rf) * pcos, 14), -32768, 32767);
      cpi = clip(rshift(rf_ext(rf) * psin, 14), -32768, 32767);
      phi = root_round(cg * cg + cpr * cpr + cpi * cpi);
      if (phi > 0) begin
        nx = unit_part(cpr, phi); ny = unit_part(cpi, phi); nz = unit_part(cg, phi);
      end else begin
        nx = 0; ny = 0; nz = 65536;
      end
      // Half angle by CORDIC, folded into the right half plane.
      z = phi * (longint'(1) << 17);
      x = Q30_GAIN; y = 0; flip = 0;
      while (z > Q30_PI) z = z - Q30_TWO_PI;
      if (z > Q30_HALF_PI) begin
        z = Q30_PI - z; flip = 1;
      end else if (z < -Q30_HALF_PI) begin
        z = -Q30_PI - z; flip = 1;
      end
      for (int i = 0; i < STEPS; i++) begin
        at = atan_q30(i[CNT_W-1:0]);
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); z = z - at;
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); z = z + at;
        end
        x = t;
      end
      c = rshift(x, 14);
      s = rshift(y, 14);
      if (flip) c = -c;
      al1 = rshift(nz * s, 16);
      be0 = rshift(ny * s, 16);
      be1 = rshift(nx * s, 16);
      na0 = c * ar - al1 * ai - be0 * br - be1 * bi;
      na1 = c * ai + al1 * ar - be1 * br + be0 * bi;
      nb0 = c * br - al1 * bi + be0 * ar + be1 * ai;
      nb1 = c * bi + al1 * br + be1 * ar - be0 * ai;
      ar = clip(rshift(na0, 16), -131072, 131071);
      ai = clip(rshift(na1, 16), -131072, 131071);
      br = clip(rshift(nb0, 16), -131072, 131071);
      bi = clip(rshift(nb1, 16), -131072, 131071);
      e.are = ar[17:0]; e.aim = ai[17:0]; e.bre = br[17:0]; e.bim = bi[17:0];
      e.fin = l;
      pending.push_back(e);
    endfunction

    // Checks one result against the oldest prediction.
    function void check_result(spinor_t got);
      spinor_t e;
      if (pending.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.are !== e.are) begin
        $error("alpha_re expected %0d got %0d", e.are, got.are); errors++;
      end
      if (got.aim !== e.aim) begin
        $error("alpha_im expected %0d got %0d", e.aim, got.aim); errors++;
      end
      if (got.bre !== e.bre) begin
        $error("beta_re expected %0d got %0d", e.bre, got.bre); errors++;
      end
      if (got.bim !== e.bim) begin
        $error("beta_im expected %0d got %0d", e.bim, got.bim); errors++;
      end
      if (got.fin !== e.fin) begin
        $error("final_res expected %0d got %0d", e.fin, got.fin); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid, in_stall, in_first, in_last;
  logic signed [15:0] in_rf_sample, in_gradient_sample;
  logic out_valid, out_stall, out_final_res;
  logic signed [17:0] out_alpha_re, out_alpha_im, out_beta_re, out_beta_im;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  spinor_board board;
  longint cycles;
  bit calm;

  cayley_klein_rf_rotation #(.CORDIC_STEPS(STEPS)) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, check every accepted item.
  initial begin
    spinor_t got;
    int burst;
    out_stall = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.are = out_alpha_re; got.aim = out_alpha_im;
        got.bre = out_beta_re; got.bim = out_beta_im; got.fin = out_final_res;
        board.check_result(got);
      end
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Valid stays high after the write so back-to-back writes need one assignment per edge.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  // Valid is dropped only before an idle gap or by drain().
  task automatic send_item(logic [15:0] rf, logic [15:0] gr, logic f, logic l);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rf_sample <= rf;
    in_gradient_sample <= gr;
    in_first <= f;
    in_last <= l;
    do @(posedge clk); while (in_stall);
    board.note_item(rf, gr, f, l);
  endtask

  // Waits until all predictions are checked, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_regs(logic [15:0] p, logic [15:0] c, logic [15:0] s);
    write_reg(REG_POSITION, p);
    write_reg(REG_PHASE_COS, c);
    write_reg(REG_PHASE_SIN, s);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_pulses(int n);
    int len, k;
    k = 0;
    while (k < n) begin
      len = $urandom_range(1, 12);
      for (int j = 0; j < len && k < n; j++, k++) begin
        if ($urandom_range(0, 9) == 0)
          send_item(16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 3) == 0)
          send_item(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    j == 0, j == len - 1);
        else
          send_item(16'($signed($urandom_range(0, 6000)) - 3000),
                    16'($signed($urandom_range(0, 6000)) - 3000), j == 0, j == len - 1);
      end
    end
  endtask

  initial begin
    board = new();
    cycles = 0;
    calm = 0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_rf_sample = '0; in_gradient_sample = '0;
    in_first = 1'b0; in_last = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_POSITION; cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset registers, zero angle, extremes and restarts.
    send_item(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_item(16'sd4096, 16'sd0, 1'b0, 1'b0);
    send_item(16'h7fff, 16'h7fff, 1'b0, 1'b1);
    send_item(16'h8000, 16'h8000, 1'b1, 1'b0);
    send_item(16'hffff, 16'h0001, 1'b1, 1'b1);
    drain();
    set_regs(16'h7fff, 16'h4000, 16'h4000);
    send_item(16'h7fff, 16'h7fff, 1'b1, 1'b0);
    send_item(16'h8000, 16'h8000, 1'b0, 1'b0);
    send_item(16'sd0, 16'sd1, 1'b0, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b0, 1'b1);
    drain();
    set_regs(16'h8000, 16'hc000, 16'hc000);
    send_item(16'h7fff, 16'h8000, 1'b1, 1'b0);
    send_item(16'h8000, 16'h7fff, 1'b0, 1'b0);
    send_item(16'sd12868, 16'sd0, 1'b0, 1'b1);
    drain();
    // Out-of-range phase values are used as given.
    set_regs(16'h1000, 16'h7fff, 16'h8000);
    send_item(16'h7fff, 16'sd100, 1'b1, 1'b0);
    send_item(16'h8000, 16'hff00, 1'b0, 1'b1);
    drain();

    // Random phases with varied register settings.
    for (int ph = 0; ph < 8; ph++) begin
      set_regs(16'($urandom), 16'($signed($urandom_range(0, 32768)) - 16384),
               16'($signed($urandom_range(0, 32768)) - 16384));
      random_pulses(220);
      drain();
    end
    set_regs(16'sd2048, 16'sd16384, 16'sd0);
    calm = 1;
    random_pulses(200);
    drain();

    if (board.errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/ckrot_pkg.sv
sv/ckrot_ctrl.sv
sv/ckrot_dp.sv
sv/cayley_klein_rf_rotation.sv
sv/ckrot_chk.sv
tb/cayley_klein_rf_rotation_tb.sv
